FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/irr_pkg.sv
// ----------------------------------------------------------------------------
// irr_pkg
// types and constants of the irq redirection router
// ----------------------------------------------------------------------------
package irr_pkg;

	typedef enum logic [1:0] {
		OP_WR_OVERRIDE   = 2'd0,
		OP_WR_CONTROLLER = 2'd1,
		OP_ROUTE         = 2'd2
	} op_t;

	// mode code that means active low / level triggered
	localparam logic [1:0] CODE_ACTIVE  = 2'b11;
	localparam int         POLARITY_BIT = 13;
	localparam int         TRIGGER_BIT  = 15;
	localparam int         DEST_SHIFT   = 56;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  irq;
		logic        override_present;
		logic [31:0] override_target;
		logic [3:0]  override_mode;
		logic [3:0]  controller_slot;
		logic        controller_present;
		logic [31:0] range_base;
		logic [7:0]  last_entry;
		logic [7:0]  destination;
		logic [7:0]  vector;
	} req_t;

	typedef struct packed {
		logic        routed;
		logic [3:0]  chosen_controller;
		logic [7:0]  entry_number;
		logic [63:0] redirection_word;
	} rsp_t;

	typedef struct packed {
		logic        en;
		logic        present;
		logic [7:0]  irq;
		logic [31:0] gsi;
		logic [3:0]  mode;
	} ovr_wr_t;

	typedef struct packed {
		logic        en;
		logic        present;
		logic [3:0]  slot;
		logic [31:0] base;
		logic [7:0]  last;
	} ctl_wr_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  slot;
		logic [7:0]  entry;
	} ctl_match_t;

endpackage

FILE: design/irr_stream_if.sv
// ----------------------------------------------------------------------------
// irr_stream_if
// valid/ready channel carrying one item of a packed payload type
// ----------------------------------------------------------------------------
interface irr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/irr_override_mem.sv
// ----------------------------------------------------------------------------
// irr_override_mem
// override table: gsi/mode memory with registered read, valid bits in flops
// ----------------------------------------------------------------------------
module irr_override_mem #(
	parameter int SLOTS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  irr_pkg::ovr_wr_t wr,
	input  logic             rd_en,
	input  logic [7:0]       rd_irq,
	output logic             hit_s1,
	output logic [31:0]      gsi_s1,
	output logic [3:0]       mode_s1
);
	import irr_pkg::*;

	localparam int AW = $clog2(SLOTS);

	logic [35:0]      mem [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic             rd_in_range;

	assign rd_in_range = ({1'b0, rd_irq} < 9'(SLOTS));

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.irq[AW-1:0]] <= {wr.gsi, wr.mode};
		end
		if (rd_en) begin
			{gsi_s1, mode_s1} <= mem[rd_irq[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.irq[AW-1:0]] <= wr.present;
			end
			if (rd_en) begin
				hit_s1 <= rd_in_range && valid_q[rd_irq[AW-1:0]];
			end
		end
	end
endmodule

FILE: design/irr_ctl_match.sv
// ----------------------------------------------------------------------------
// irr_ctl_match
// controller table and parallel range compare, highest valid slot wins
// ----------------------------------------------------------------------------
module irr_ctl_match #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  irr_pkg::ctl_wr_t    wr,
	input  logic [31:0]         gsi,
	output irr_pkg::ctl_match_t match
);
	import irr_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] valid_q;
	logic [31:0]      base_q [SLOTS];
	logic [7:0]       last_q [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			base_q[wr.slot[IW-1:0]] <= wr.base;
			last_q[wr.slot[IW-1:0]] <= wr.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.slot[IW-1:0]] <= wr.present;
		end
	end

	// range end is kept at 33 bits so it never wraps
	always_comb begin
		logic [32:0] top;
		logic [31:0] diff;
		match = '0;
		for (int i = 0; i < SLOTS; i++) begin
			top  = {1'b0, base_q[i]} + {25'b0, last_q[i]};
			diff = gsi - base_q[i];
			if (valid_q[i] && (base_q[i] <= gsi) && ({1'b0, gsi} <= top)) begin
				match.hit   = 1'b1;
				match.slot  = 4'(i);
				match.entry = diff[7:0];
			end
		end
	end
endmodule

FILE: design/irq_redirection_router.sv
// ----------------------------------------------------------------------------
// irq_redirection_router
// irq to i/o interrupt controller routing with source overrides
// ----------------------------------------------------------------------------
// Each req item yields exactly one rsp item. Items either load an override
// slot, load a controller slot, or route an irq. The override memory read is
// launched in the cycle in which an item is accepted. The parallel range
// compare over the controller table and the build of the redirection entry
// follow in the next cycle. The result then moves from stage 1 into the
// output register as soon as that register is empty or being drained, and
// is held there until the rsp side takes it. A new
// item is accepted every cycle as long as the output register is empty or is
// being drained, so a stalled rsp side holds at most one item in flight plus
// one finished result. Writes go into the tables at acceptance, so a route
// right after a write already sees it. A route with no override uses the irq
// as the global interrupt number with polarity and trigger bits clear; of
// several covering controllers the highest valid slot wins. Misses, writes
// beyond the table sizes and the unused operation code answer routed 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irq_redirection_router #(
	parameter int OVERRIDE_SLOTS   = 256,
	parameter int CONTROLLER_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	irr_stream_if.sink          req,
	irr_stream_if.source        rsp
);
	import irr_pkg::*;

	// only 16 controller slots can be addressed by the 4-bit slot field
	localparam int NCTL = (CONTROLLER_SLOTS < 16) ? CONTROLLER_SLOTS : 16;

	// handshake
	logic accept;
	logic out_free;

	// stage 1: item waiting on the override read
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] irq_s1;
	logic [7:0] dest_s1;
	logic [7:0] vec_s1;
	logic       wr_ok_s1;

	// table access
	ovr_wr_t     ovr_wr;
	ctl_wr_t     ctl_wr;
	logic        ovr_hit_s1;
	logic [31:0] ovr_gsi_s1;
	logic [3:0]  ovr_mode_s1;
	logic [31:0] gsi;
	logic [3:0]  mode;
	ctl_match_t  match;

	logic ovr_in_range;
	logic ctl_in_range;

	// result
	rsp_t result;
	logic out_valid_q;
	rsp_t out_q;

	assign out_free  = !out_valid_q || rsp.ready;
	// stage 1 always drains when the output register can take it
	assign req.ready = !valid_s1 || out_free;
	assign accept    = req.valid && req.ready;

	assign ovr_in_range = ({1'b0, req.data.irq} < 9'(OVERRIDE_SLOTS));
	assign ctl_in_range = ({3'b0, req.data.controller_slot} < 7'(NCTL));

	// table writes happen at acceptance
	always_comb begin
		ovr_wr.en      = accept && (req.data.operation == OP_WR_OVERRIDE) && ovr_in_range;
		ovr_wr.present = req.data.override_present;
		ovr_wr.irq     = req.data.irq;
		ovr_wr.gsi     = req.data.override_target;
		ovr_wr.mode    = req.data.override_mode;

		ctl_wr.en      = accept && (req.data.operation == OP_WR_CONTROLLER) && ctl_in_range;
		ctl_wr.present = req.data.controller_present;
		ctl_wr.slot    = req.data.controller_slot;
		ctl_wr.base    = req.data.range_base;
		ctl_wr.last    = req.data.last_entry;
	end

	irr_override_mem #(
		.SLOTS(OVERRIDE_SLOTS)
	) u_ovr (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (ovr_wr),
		.rd_en  (accept),
		.rd_irq (req.data.irq),
		.hit_s1 (ovr_hit_s1),
		.gsi_s1 (ovr_gsi_s1),
		.mode_s1(ovr_mode_s1)
	);

	// without an override the irq is the gsi and the mode is neutral
	assign gsi  = ovr_hit_s1 ? ovr_gsi_s1 : {24'b0, irq_s1};
	assign mode = ovr_hit_s1 ? ovr_mode_s1 : 4'b0;

	irr_ctl_match #(
		.SLOTS(NCTL)
	) u_ctl (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (ctl_wr),
		.gsi   (gsi),
		.match (match)
	);

	// stage 1 registers: control reset, payload free-running on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.data.operation;
			irq_s1  <= req.data.irq;
			dest_s1 <= req.data.destination;
			vec_s1  <= req.data.vector;
			unique case (req.data.operation)
				OP_WR_OVERRIDE:   wr_ok_s1 <= ovr_in_range;
				OP_WR_CONTROLLER: wr_ok_s1 <= ctl_in_range;
				default:          wr_ok_s1 <= 1'b0;
			endcase
		end
	end

	// build the result item from the compare outcome
	always_comb begin
		result = '0;
		unique case (op_s1)
			OP_WR_OVERRIDE, OP_WR_CONTROLLER: begin
				result.routed = wr_ok_s1;
			end
			OP_ROUTE: begin
				if (match.hit) begin
					result.routed            = 1'b1;
					result.chosen_controller = match.slot;
					result.entry_number      = match.entry;
					result.redirection_word[7:0] = vec_s1;
					result.redirection_word[POLARITY_BIT] = (mode[1:0] == CODE_ACTIVE);
					result.redirection_word[TRIGGER_BIT]  = (mode[3:2] == CODE_ACTIVE);
					result.redirection_word[DEST_SHIFT +: 8] = dest_s1;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	// output register, refilled whenever it is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_q <= result;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// stage 1 must not be overwritten while its result cannot leave
	`ASSERT_SAME(a_interlock, clk, arst_n, valid_s1 && !out_free, !req.ready)
	// every accepted item occupies stage 1 in the next cycle
	`ASSERT_NEXT(a_enter_s1, clk, arst_n, accept, valid_s1)
	// a stage-1 item moves into the output register when it is free
	`ASSERT_NEXT(a_drain_s1, clk, arst_n, valid_s1 && out_free, out_valid_q)
	// a miss or write never carries route fields
	`ASSERT_SAME(a_miss_clean, clk, arst_n, out_valid_q && (out_q.redirection_word != 64'b0),
		out_q.routed)
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the irq redirection router: a queue-fed driver sends
// override, controller, route and reserved-code items, a shadow copy of both
// tables predicts every response, and a monitor compares them in order
// ----------------------------------------------------------------------------
module tb_top;
	import irr_pkg::*;

	// table sizes, shared by the dut instance and the shadow tables
	localparam int OVR_SLOTS = 256;
	localparam int CTL_SLOTS = 16;

	// operation code that the block does not define
	localparam op_t OP_RESERVED = op_t'(2'd3);

	// run length guard, far above the slowest legal run
	localparam int CYCLE_LIMIT  = 300000;
	// cycles allowed after the last response for anything stray to show up
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 700;

	logic clk;
	logic arst_n;

	irr_stream_if #(.T(req_t)) req_if ();
	irr_stream_if #(.T(rsp_t)) rsp_if ();

	irq_redirection_router #(
		.OVERRIDE_SLOTS   (OVR_SLOTS),
		.CONTROLLER_SLOTS (CTL_SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// ------------------------------------------------------------------------
	// shadow tables, updated when a write item is accepted
	// ------------------------------------------------------------------------
	logic        shadow_ovr_valid [OVR_SLOTS];
	logic [31:0] shadow_ovr_gsi   [OVR_SLOTS];
	logic [3:0]  shadow_ovr_mode  [OVR_SLOTS];
	logic        shadow_ctl_valid [CTL_SLOTS];
	logic [31:0] shadow_ctl_base  [CTL_SLOTS];
	logic [7:0]  shadow_ctl_top   [CTL_SLOTS];

	req_t pending_reqs[$];     // items not yet handed to the driver
	rsp_t expected_routes[$];  // predicted responses, oldest first

	int   items_sent;
	int   hold_points[3];      // item counts at which the sender drains the dut
	int   phase_edge[2];       // item counts at which the idling pattern changes
	int   mismatches;
	int   cycle_count;
	logic req_fire;
	int   sender_roll;
	int   receiver_roll;

	// ------------------------------------------------------------------------
	// predictor: applies one accepted item to the shadow tables and returns
	// the response the dut owes for it
	// ------------------------------------------------------------------------
	function automatic rsp_t route_item(req_t it);
		rsp_t        res;
		logic [31:0] gsi;
		logic [3:0]  mode;
		logic [32:0] span_end;
		res = '0;
		case (it.operation)
			OP_WR_OVERRIDE: begin
				// slots past the table size are dropped and answer routed 0
				if (int'(it.irq) < OVR_SLOTS) begin
					shadow_ovr_valid[it.irq] = it.override_present;
					shadow_ovr_gsi[it.irq]   = it.override_target;
					shadow_ovr_mode[it.irq]  = it.override_mode;
					res.routed = 1'b1;
				end
			end
			OP_WR_CONTROLLER: begin
				if (int'(it.controller_slot) < CTL_SLOTS) begin
					shadow_ctl_valid[it.controller_slot] = it.controller_present;
					shadow_ctl_base[it.controller_slot]  = it.range_base;
					shadow_ctl_top[it.controller_slot]   = it.last_entry;
					res.routed = 1'b1;
				end
			end
			OP_ROUTE: begin
				// no override: gsi is the irq itself, polarity and trigger clear
				gsi  = {24'd0, it.irq};
				mode = 4'd0;
				if (int'(it.irq) < OVR_SLOTS && shadow_ovr_valid[it.irq]) begin
					gsi  = shadow_ovr_gsi[it.irq];
					mode = shadow_ovr_mode[it.irq];
				end
				// the range end is kept at 33 bits so it never wraps; the
				// highest covering slot wins, so later hits overwrite
				for (int i = 0; i < CTL_SLOTS; i++) begin
					if (shadow_ctl_valid[i]) begin
						span_end = {1'b0, shadow_ctl_base[i]} + {25'd0, shadow_ctl_top[i]};
						if (shadow_ctl_base[i] <= gsi && {1'b0, gsi} <= span_end) begin
							res.routed            = 1'b1;
							res.chosen_controller = 4'(i);
							res.entry_number      = 8'(gsi - shadow_ctl_base[i]);
						end
					end
				end
				if (res.routed) begin
					res.redirection_word[7:0]            = it.vector;
					res.redirection_word[POLARITY_BIT]   = (mode[1:0] == CODE_ACTIVE);
					res.redirection_word[TRIGGER_BIT]    = (mode[3:2] == CODE_ACTIVE);
					res.redirection_word[DEST_SHIFT +: 8] = it.destination;
				end
			end
			default: ;  // reserved code: no table change, all fields zero
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// item builders; unused fields carry random bits so every bit toggles
	// ------------------------------------------------------------------------
	function automatic req_t noise_item();
		req_t it;
		it = '0;
		it.operation          = op_t'(2'($urandom_range(0, 3)));
		it.irq                = 8'($urandom);
		it.override_present   = 1'($urandom);
		it.override_target    = $urandom;
		it.override_mode      = 4'($urandom);
		it.controller_slot    = 4'($urandom);
		it.controller_present = 1'($urandom);
		it.range_base         = $urandom;
		it.last_entry         = 8'($urandom);
		it.destination        = 8'($urandom);
		it.vector             = 8'($urandom);
		return it;
	endfunction

	function automatic req_t wr_override(logic [7:0] irq, logic present,
	                                     logic [31:0] target, logic [3:0] mode);
		req_t it;
		it = noise_item();
		it.operation        = OP_WR_OVERRIDE;
		it.irq              = irq;
		it.override_present = present;
		it.override_target  = target;
		it.override_mode    = mode;
		return it;
	endfunction

	function automatic req_t wr_controller(logic [3:0] slot, logic present,
	                                       logic [31:0] base, logic [7:0] top_entry);
		req_t it;
		it = noise_item();
		it.operation          = OP_WR_CONTROLLER;
		it.controller_slot    = slot;
		it.controller_present = present;
		it.range_base         = base;
		it.last_entry         = top_entry;
		return it;
	endfunction

	function automatic req_t route_req(logic [7:0] irq, logic [7:0] dest, logic [7:0] vec);
		req_t it;
		it = noise_item();
		it.operation   = OP_ROUTE;
		it.irq         = irq;
		it.destination = dest;
		it.vector      = vec;
		return it;
	endfunction

	// random traffic, mostly well-formed so routes actually land on controllers
	function automatic req_t random_item();
		int          pick;
		int          shape;
		logic [31:0] val;
		pick  = $urandom_range(0, 99);
		shape = $urandom_range(0, 99);
		if (pick < 15) begin
			// controller bases cluster low, some near the top of the gsi space
			if (shape < 70)
				val = 32'($urandom_range(0, 300));
			else if (shape < 85)
				val = 32'hFFFF_FE00 | 32'($urandom_range(0, 511));
			else
				val = $urandom;
			return wr_controller(4'($urandom), ($urandom_range(0, 9) != 0), val,
			                     8'($urandom));
		end else if (pick < 30) begin
			if (shape < 60)
				val = 32'($urandom_range(0, 600));
			else if (shape < 80)
				val = 32'hFFFF_FE00 | 32'($urandom_range(0, 511));
			else
				val = $urandom;
			return wr_override(8'($urandom_range(0, 63)) | (($urandom_range(0, 4) == 0) ?
			                   8'($urandom) : 8'd0),
			                   ($urandom_range(0, 4) != 0), val, 4'($urandom));
		end else if (pick < 95) begin
			return route_req(($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 63)) :
			                 8'($urandom), 8'($urandom), 8'($urandom));
		end
		return noise_item();
	endfunction

	// idling pattern per phase of the run, in percent of cycles
	function automatic int sender_idle_pct(int sent);
		if (sent < phase_edge[0])
			return 38;
		else if (sent < phase_edge[1])
			return 46;
		return 0;
	endfunction

	function automatic int receiver_idle_pct(int sent);
		if (sent < phase_edge[0])
			return 46;
		else if (sent < phase_edge[1])
			return 38;
		return 0;
	endfunction

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle guard: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// driver: presents the next pending item at the falling edge once the
	// previous one is taken; random gaps, and a full drain at hold points
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_fire) begin
			sender_roll = $urandom_range(0, 99);
			if (pending_reqs.size() != 0 && sender_roll >= sender_idle_pct(items_sent) &&
			    !((items_sent == hold_points[0] || items_sent == hold_points[1] ||
			       items_sent == hold_points[2]) && expected_routes.size() != 0)) begin
				req_if.valid <= 1'b1;
				req_if.data  <= pending_reqs.pop_front();
				items_sent   <= items_sent + 1;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, random per phase, off in the last phase
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			receiver_roll = $urandom_range(0, 99);
			rsp_if.ready <= (receiver_roll >= receiver_idle_pct(items_sent));
		end
	end

	// ------------------------------------------------------------------------
	// request side monitor: every accepted item goes through the predictor
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		req_fire <= arst_n && req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready)
			expected_routes.push_back(route_item(req_if.data));
	end

	// ------------------------------------------------------------------------
	// response side monitor: in-order, field by field compare
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (expected_routes.size() == 0) begin
				$error("unexpected response item: %h", got);
				mismatches = mismatches + 1;
			end else begin
				want = expected_routes.pop_front();
				if (got.routed !== want.routed) begin
					$error("routed: expected %0h, got %0h", want.routed, got.routed);
					mismatches = mismatches + 1;
				end
				if (got.chosen_controller !== want.chosen_controller) begin
					$error("chosen_controller: expected %0h, got %0h",
					       want.chosen_controller, got.chosen_controller);
					mismatches = mismatches + 1;
				end
				if (got.entry_number !== want.entry_number) begin
					$error("entry_number: expected %0h, got %0h",
					       want.entry_number, got.entry_number);
					mismatches = mismatches + 1;
				end
				if (got.redirection_word !== want.redirection_word) begin
					$error("redirection_word: expected %h, got %h",
					       want.redirection_word, got.redirection_word);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int n_directed;
		int n_total;

		// known values on every input from time zero
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		req_fire     = 1'b0;
		items_sent   = 0;
		mismatches   = 0;
		cycle_count  = 0;
		for (int i = 0; i < OVR_SLOTS; i++)
			shadow_ovr_valid[i] = 1'b0;
		for (int i = 0; i < CTL_SLOTS; i++)
			shadow_ctl_valid[i] = 1'b0;

		// directed part
		// empty tables: route misses
		pending_reqs.push_back(route_req(8'd0, 8'hFF, 8'hFF));
		// reserved operation code
		begin
			req_t it;
			it = noise_item();
			it.operation = OP_RESERVED;
			pending_reqs.push_back(it);
		end
		// range check includes the last entry, one past it misses
		pending_reqs.push_back(wr_controller(4'd0, 1'b1, 32'd0, 8'd23));
		pending_reqs.push_back(route_req(8'd23, 8'hFF, 8'hFF));
		pending_reqs.push_back(route_req(8'd24, 8'h00, 8'h00));
		// range end past 32 bits, override to the top gsi, both mode bits set
		pending_reqs.push_back(wr_controller(4'd15, 1'b1, 32'hFFFF_FF80, 8'hFF));
		pending_reqs.push_back(wr_override(8'd255, 1'b1, 32'hFFFF_FFFF, 4'hF));
		pending_reqs.push_back(route_req(8'd255, 8'h5A, 8'hA5));
		// polarity only, trigger only, neither (codes other than active)
		pending_reqs.push_back(wr_override(8'd1, 1'b1, 32'd5, 4'b0111));
		pending_reqs.push_back(route_req(8'd1, 8'h01, 8'h30));
		pending_reqs.push_back(wr_override(8'd2, 1'b1, 32'd6, 4'b1101));
		pending_reqs.push_back(route_req(8'd2, 8'h80, 8'h31));
		pending_reqs.push_back(wr_override(8'd4, 1'b1, 32'd7, 4'b1010));
		pending_reqs.push_back(route_req(8'd4, 8'h7F, 8'h32));
		// overlapping controllers: the higher slot wins, then falls back
		pending_reqs.push_back(wr_controller(4'd7, 1'b1, 32'd0, 8'd10));
		pending_reqs.push_back(route_req(8'd3, 8'h11, 8'h40));
		pending_reqs.push_back(wr_controller(4'd7, 1'b0, 32'd0, 8'd10));
		pending_reqs.push_back(route_req(8'd3, 8'h22, 8'h41));
		// cleared override: gsi falls back to the irq
		pending_reqs.push_back(wr_override(8'd1, 1'b0, 32'd5, 4'hF));
		pending_reqs.push_back(route_req(8'd1, 8'h33, 8'h42));
		// all-zero vector and destination on a hit at entry zero
		pending_reqs.push_back(route_req(8'd0, 8'h00, 8'h00));
		// cleared top controller: the top gsi misses again
		pending_reqs.push_back(wr_controller(4'd15, 1'b0, 32'hFFFF_FF80, 8'hFF));
		pending_reqs.push_back(route_req(8'd255, 8'hFF, 8'hFF));
		n_directed = pending_reqs.size();

		// random part
		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending_reqs.push_back(random_item());
		n_total = pending_reqs.size();

		// three idling phases; the sender drains the dut at each boundary
		phase_edge[0]  = n_directed + (n_total - n_directed) / 3;
		phase_edge[1]  = n_directed + 2 * (n_total - n_directed) / 3;
		hold_points[0] = n_directed;
		hold_points[1] = phase_edge[0];
		hold_points[2] = phase_edge[1];

		// reset from time zero, released at a falling edge away from the sampling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all items accepted, then all responses back, then a short drain
		while (pending_reqs.size() != 0 || req_if.valid)
			@(posedge clk);
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_routes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
